// ----- rtl/xlf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlf_pkg
// Shared types, codes and helpers for the lazy flags evaluator pipeline.
// ----------------------------------------------------------------------------
package xlf_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FlagsW = 12;

  localparam logic [3:0] CMD_ADD   = 4'd0;
  localparam logic [3:0] CMD_SUB   = 4'd1;
  localparam logic [3:0] CMD_LOGIC = 4'd2;
  localparam logic [3:0] CMD_INC   = 4'd3;
  localparam logic [3:0] CMD_DEC   = 4'd4;
  localparam logic [3:0] CMD_SHL   = 4'd5;
  localparam logic [3:0] CMD_SAR   = 4'd6;
  localparam logic [3:0] CMD_MUL   = 4'd7;
  localparam logic [3:0] CMD_BMI   = 4'd8;
  localparam logic [3:0] CMD_ADC   = 4'd9;

  localparam logic [1:0] SIZE_BYTE  = 2'd0;
  localparam logic [1:0] SIZE_WORD  = 2'd1;
  localparam logic [1:0] SIZE_DWORD = 2'd2;
  localparam logic [1:0] SIZE_QWORD = 2'd3;

  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 2;
  localparam int unsigned FLAG_AF = 4;
  localparam int unsigned FLAG_ZF = 6;
  localparam int unsigned FLAG_SF = 7;
  localparam int unsigned FLAG_OF = 11;

  // stage 1: operands masked to size
  typedef struct packed {
    logic [3:0]       cmd;
    logic [1:0]       size;
    logic [DataW-1:0] d;
    logic [DataW-1:0] s;
    logic             carry_in;
    logic             src_b0;
    logic             src_nz;
  } s1_t;

  // stage 2: sums, compares and reductions
  typedef struct packed {
    logic [3:0]       cmd;
    logic [1:0]       size;
    logic [DataW-1:0] d;
    logic [DataW-1:0] s;
    logic [DataW-1:0] t_add;
    logic [DataW-1:0] t_sub;
    logic             cf_sub;
    logic             lt;
    logic             eq;
    logic             d_zero;
    logic             s_zero;
    logic             par_even;
    logic             af_inc;
    logic             af_dec;
    logic             of_inc;
    logic             of_dec;
    logic             carry_in;
    logic             src_b0;
    logic             src_nz;
  } s2_t;

  function automatic logic [DataW-1:0] size_mask(input logic [1:0] size);
    logic [DataW-1:0] m;
    unique case (size)
      SIZE_BYTE:  m = 64'h0000_0000_0000_00FF;
      SIZE_WORD:  m = 64'h0000_0000_0000_FFFF;
      SIZE_DWORD: m = 64'h0000_0000_FFFF_FFFF;
      SIZE_QWORD: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [DataW-1:0] sign_val(input logic [1:0] size);
    logic [DataW-1:0] v;
    unique case (size)
      SIZE_BYTE:  v = 64'h0000_0000_0000_0080;
      SIZE_WORD:  v = 64'h0000_0000_0000_8000;
      SIZE_DWORD: v = 64'h0000_0000_8000_0000;
      SIZE_QWORD: v = 64'h8000_0000_0000_0000;
    endcase
    return v;
  endfunction

  function automatic logic top_bit(input logic [DataW-1:0] v, input logic [1:0] size);
    logic b;
    unique case (size)
      SIZE_BYTE:  b = v[7];
      SIZE_WORD:  b = v[15];
      SIZE_DWORD: b = v[31];
      SIZE_QWORD: b = v[63];
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/xlf_mask.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlf_mask
// Stage 1: unpacks the request and masks result and source to operand size.
// ----------------------------------------------------------------------------
module xlf_mask (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [3:0]                     cmd_i,
  input  logic [1:0]                     size_i,
  input  logic [xlf_pkg::DataW-1:0]      result_i,
  input  logic [xlf_pkg::DataW-1:0]      source_i,
  input  logic                           carry_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output xlf_pkg::s1_t                   data_o
);

  logic         valid_r;
  xlf_pkg::s1_t data_r;
  xlf_pkg::s1_t data_nxt;
  logic [xlf_pkg::DataW-1:0] m;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    m                 = xlf_pkg::size_mask(size_i);
    data_nxt.cmd      = cmd_i;
    data_nxt.size     = size_i;
    data_nxt.d        = result_i & m;
    data_nxt.s        = source_i & m;
    data_nxt.carry_in = carry_i;
    data_nxt.src_b0   = source_i[0];
    data_nxt.src_nz   = |source_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/xlf_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlf_arith
// Stage 2: wide add/subtract, compares, parity and per-kind detections.
// ----------------------------------------------------------------------------
module xlf_arith (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         valid_i,
  output logic         ready_o,
  input  xlf_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output xlf_pkg::s2_t data_o
);

  logic         valid_r;
  xlf_pkg::s2_t data_r;
  xlf_pkg::s2_t data_nxt;
  logic [xlf_pkg::DataW-1:0] m;
  logic [xlf_pkg::DataW-1:0] sv;
  logic [xlf_pkg::DataW:0]   sum;
  logic                      cout;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign data_o  = data_r;

  always_comb begin
    m   = xlf_pkg::size_mask(data_i.size);
    sv  = xlf_pkg::sign_val(data_i.size);
    sum = {1'b0, data_i.d} + {1'b0, data_i.s};
    unique case (data_i.size)
      xlf_pkg::SIZE_BYTE:  cout = sum[8];
      xlf_pkg::SIZE_WORD:  cout = sum[16];
      xlf_pkg::SIZE_DWORD: cout = sum[32];
      xlf_pkg::SIZE_QWORD: cout = sum[64];
    endcase
    data_nxt.cmd      = data_i.cmd;
    data_nxt.size     = data_i.size;
    data_nxt.d        = data_i.d;
    data_nxt.s        = data_i.s;
    data_nxt.t_add    = (data_i.d - data_i.s) & m;
    data_nxt.t_sub    = sum[xlf_pkg::DataW-1:0] & m;
    data_nxt.cf_sub   = cout;
    data_nxt.lt       = data_i.d < data_i.s;
    data_nxt.eq       = data_i.d == data_i.s;
    data_nxt.d_zero   = data_i.d == '0;
    data_nxt.s_zero   = data_i.s == '0;
    data_nxt.par_even = ~(^data_i.d[7:0]);
    // borrow/carry into bit 4 of d -/+ 1
    data_nxt.af_inc   = data_i.d[3:0] == 4'h0;
    data_nxt.af_dec   = data_i.d[3:0] == 4'hF;
    data_nxt.of_inc   = data_i.d == sv;
    data_nxt.of_dec   = data_i.d == (sv - 64'd1);
    data_nxt.carry_in = data_i.carry_in;
    data_nxt.src_b0   = data_i.src_b0;
    data_nxt.src_nz   = data_i.src_nz;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ----- rtl/xlf_flags.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xlf_flags
// Stage 3: selects flags by kind and holds the output register.
// ----------------------------------------------------------------------------
module xlf_flags (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  xlf_pkg::s2_t                   data_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output logic [xlf_pkg::FlagsW-1:0]     flags_o
);

  logic                          valid_r;
  logic [xlf_pkg::FlagsW-1:0]    flags_r;
  logic [xlf_pkg::FlagsW-1:0]    flags_nxt;
  logic                          cf;
  logic                          af;
  logic                          of;
  logic                          pf;
  logic                          sf;

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign flags_o = flags_r;

  always_comb begin
    cf = 1'b0;
    af = 1'b0;
    of = 1'b0;
    pf = data_i.par_even;
    sf = xlf_pkg::top_bit(data_i.d, data_i.size);
    flags_nxt = '0;
    unique case (data_i.cmd)
      xlf_pkg::CMD_ADD: begin
        cf = data_i.lt;
        af = data_i.d[4] ^ data_i.s[4] ^ data_i.t_add[4];
        of = xlf_pkg::top_bit(~(data_i.s ^ data_i.t_add) & (data_i.s ^ data_i.d),
                              data_i.size);
      end
      xlf_pkg::CMD_SUB: begin
        cf = data_i.cf_sub;
        af = data_i.d[4] ^ data_i.s[4] ^ data_i.t_sub[4];
        of = xlf_pkg::top_bit((data_i.t_sub ^ data_i.s) & (data_i.t_sub ^ data_i.d),
                              data_i.size);
      end
      xlf_pkg::CMD_LOGIC: begin
      end
      xlf_pkg::CMD_INC: begin
        cf = data_i.src_b0;
        af = data_i.af_inc;
        of = data_i.of_inc;
      end
      xlf_pkg::CMD_DEC: begin
        cf = data_i.src_b0;
        af = data_i.af_dec;
        of = data_i.of_dec;
      end
      xlf_pkg::CMD_SHL: begin
        cf = xlf_pkg::top_bit(data_i.s, data_i.size);
        of = xlf_pkg::top_bit(data_i.s ^ data_i.d, data_i.size);
      end
      xlf_pkg::CMD_SAR: begin
        cf = data_i.s[0];
        of = xlf_pkg::top_bit(data_i.s ^ data_i.d, data_i.size);
      end
      xlf_pkg::CMD_MUL: begin
        cf = data_i.src_nz;
        of = data_i.src_nz;
      end
      xlf_pkg::CMD_BMI: begin
        cf = data_i.s_zero;
        pf = 1'b0;
      end
      default: begin
      end
    endcase
    flags_nxt[xlf_pkg::FLAG_CF] = cf;
    flags_nxt[xlf_pkg::FLAG_PF] = pf;
    flags_nxt[xlf_pkg::FLAG_AF] = af;
    flags_nxt[xlf_pkg::FLAG_ZF] = data_i.d_zero;
    flags_nxt[xlf_pkg::FLAG_SF] = sf;
    flags_nxt[xlf_pkg::FLAG_OF] = of;
    if (data_i.cmd == xlf_pkg::CMD_ADC) begin
      flags_nxt = '0;
      flags_nxt[xlf_pkg::FLAG_CF] = data_i.lt || (data_i.carry_in && data_i.eq);
    end else if (data_i.cmd > xlf_pkg::CMD_ADC) begin
      flags_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      flags_r <= flags_nxt;
    end
  end

endmodule

// ----- rtl/x86_lazy_flags_evaluator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_lazy_flags_evaluator_top
// Rebuilds the x86 flags word (CF PF AF ZF SF OF) from a saved result,
// source, operation kind and operand size; adc kind returns only the carry, higher kinds all zero.
//
// Input stream: in_tuser carries the operation kind, in_tdata the size,
// saved result, saved source and carry-in. One request gives one output
// request on out_tdata holding the 12-bit flags word.
// The request passes through the mask, arithmetic and flag-select register
// stages in that order. Throughput: one request per cycle while out_tready
// is high; every stage holds its own valid bit and takes new data when it
// is empty or its successor takes its contents.
// When the receiver holds out_tready low, the stages fill up one by one and
// in_tready drops only once all three hold requests; nothing is dropped or
// repeated. Reset (rst_n low, synchronous) clears all valid bits; the block
// has no other state and no configuration.
// ----------------------------------------------------------------------------
module x86_lazy_flags_evaluator_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [1:0] size_code, [65:2] result_value, [129:66] source_value,
  // [130] carry_in, [135:131] zero
  input  logic [135:0] in_tdata,
  // [3:0] command
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [11:0] flags_word, [15:12] zero
  output logic [15:0]  out_tdata
);

  logic                       s1_valid;
  logic                       s1_ready;
  xlf_pkg::s1_t               s1_data;
  logic                       s2_valid;
  logic                       s2_ready;
  xlf_pkg::s2_t               s2_data;
  logic [xlf_pkg::FlagsW-1:0] flags;

  xlf_mask u_mask (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_tvalid),
    .ready_o  (in_tready),
    .cmd_i    (in_tuser),
    .size_i   (in_tdata[1:0]),
    .result_i (in_tdata[65:2]),
    .source_i (in_tdata[129:66]),
    .carry_i  (in_tdata[130]),
    .valid_o  (s1_valid),
    .ready_i  (s1_ready),
    .data_o   (s1_data)
  );

  xlf_arith u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  xlf_flags u_flags (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (out_tvalid),
    .ready_i (out_tready),
    .flags_o (flags)
  );

  assign out_tdata = {4'd0, flags};

endmodule

// ----- sim/x86_lazy_flags_evaluator_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flags_checker
// Watches both streams of the lazy flags evaluator, computes the flags word
// each accepted request should give, and compares it with the returned one.
// ----------------------------------------------------------------------------
module flags_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [135:0] in_tdata,
  input  logic [3:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [15:0]  out_tdata,
  output int           error_count,
  output int           pending_count
);

  typedef struct packed {
    logic [3:0]  cmd;
    logic [1:0]  size;
    logic [63:0] res;
    logic [63:0] src;
    logic        cin;
  } flags_req_t;

  logic [xlf_pkg::FlagsW-1:0] flags_due[$];
  flags_req_t                 seen_req;
  logic [xlf_pkg::FlagsW-1:0] due_flags;

  function automatic logic [xlf_pkg::FlagsW-1:0] eval_flags(input flags_req_t r);
    int unsigned                w;
    logic [63:0]                m;
    logic [63:0]                d;
    logic [63:0]                s;
    logic [63:0]                t;
    logic [63:0]                x;
    logic [63:0]                sign_v;
    logic                       cf;
    logic                       pf;
    logic                       af;
    logic                       of;
    logic [xlf_pkg::FlagsW-1:0] f;
    w      = 8 << r.size;
    m      = (w == 64) ? {64{1'b1}} : ((64'd1 << w) - 64'd1);
    d      = r.res & m;
    s      = r.src & m;
    sign_v = 64'd1 << (w - 1);
    cf     = 1'b0;
    af     = 1'b0;
    of     = 1'b0;
    pf     = ~^d[7:0];
    case (r.cmd)
      xlf_pkg::CMD_ADD: begin
        t  = (d - s) & m;
        cf = d < s;
        af = d[4] ^ s[4] ^ t[4];
        x  = ~(s ^ t) & (s ^ d);
        of = x[w-1];
      end
      xlf_pkg::CMD_SUB: begin
        t  = (d + s) & m;
        cf = t < s;
        af = d[4] ^ t[4] ^ s[4];
        x  = (t ^ s) & (t ^ d);
        of = x[w-1];
      end
      xlf_pkg::CMD_LOGIC: begin
      end
      xlf_pkg::CMD_INC: begin
        cf = r.src[0];
        t  = (d - 64'd1) & m;
        af = d[4] ^ t[4];
        of = d == sign_v;
      end
      xlf_pkg::CMD_DEC: begin
        cf = r.src[0];
        t  = (d + 64'd1) & m;
        af = d[4] ^ t[4];
        of = d == sign_v - 64'd1;
      end
      xlf_pkg::CMD_SHL: begin
        cf = s[w-1];
        x  = s ^ d;
        of = x[w-1];
      end
      xlf_pkg::CMD_SAR: begin
        cf = s[0];
        x  = s ^ d;
        of = x[w-1];
      end
      xlf_pkg::CMD_MUL: begin
        cf = r.src != 64'd0;
        of = cf;
      end
      xlf_pkg::CMD_BMI: begin
        cf = s == 64'd0;
        pf = 1'b0;
      end
      xlf_pkg::CMD_ADC: begin
        f = '0;
        f[xlf_pkg::FLAG_CF] = r.cin ? (d <= s) : (d < s);
        return f;
      end
      default: begin
        return '0;
      end
    endcase
    f = '0;
    f[xlf_pkg::FLAG_CF] = cf;
    f[xlf_pkg::FLAG_PF] = pf;
    f[xlf_pkg::FLAG_AF] = af;
    f[xlf_pkg::FLAG_ZF] = d == 64'd0;
    f[xlf_pkg::FLAG_SF] = d[w-1];
    f[xlf_pkg::FLAG_OF] = of;
    return f;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t flags check: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        seen_req.cmd  = in_tuser;
        seen_req.size = in_tdata[1:0];
        seen_req.res  = in_tdata[65:2];
        seen_req.src  = in_tdata[129:66];
        seen_req.cin  = in_tdata[130];
        flags_due.push_back(eval_flags(seen_req));
      end
      if (out_tvalid && out_tready) begin
        if (flags_due.size() == 0) begin
          report_mismatch($sformatf("unexpected flags word %03h", out_tdata[11:0]));
        end else begin
          due_flags = flags_due.pop_front();
          if (out_tdata[11:0] !== due_flags)
            report_mismatch($sformatf("flags word %03h, want %03h",
                                      out_tdata[11:0], due_flags));
        end
      end
    end
    pending_count = flags_due.size();
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the lazy flags evaluator with directed corner requests and random
// requests under random stalls on both streams, one long output hold-off,
// then reports the verdict from the flags checker.
// ----------------------------------------------------------------------------
module tb;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [3:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;
  int           error_count;
  int           pending_count;

  bit           idle_on = 1'b1;
  bit           long_hold = 1'b0;

  localparam logic [63:0] ONES = {64{1'b1}};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  x86_lazy_flags_evaluator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  flags_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  task automatic send_req(input logic [3:0] cmd, input logic [1:0] size,
                          input logic [63:0] res, input logic [63:0] src,
                          input logic cin);
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, cin, src, res, size};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] pick_value(input logic [1:0] size);
    int unsigned w;
    logic [63:0] v;
    w = 8 << size;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = ONES;
      2: v = 64'd1 << (w - 1);
      3: v = (64'd1 << (w - 1)) - 64'd1;
      4: v = 64'($urandom_range(0, 255));
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  // output side: short random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [3:0]  cmd;
    logic [1:0]  size;
    logic [63:0] res;
    logic [63:0] src;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_req(xlf_pkg::CMD_ADD,   xlf_pkg::SIZE_BYTE,  64'd0, 64'd0, 1'b0);
    send_req(xlf_pkg::CMD_ADD,   xlf_pkg::SIZE_QWORD, 64'd0, 64'd1, 1'b1);
    send_req(xlf_pkg::CMD_ADD,   xlf_pkg::SIZE_BYTE,  64'h80, 64'h7F, 1'b0);
    send_req(xlf_pkg::CMD_ADD,   xlf_pkg::SIZE_BYTE,  64'hFFFF_FFFF_FFFF_FF00,
             64'h1234_5678_9ABC_DE0F, 1'b1);
    send_req(xlf_pkg::CMD_SUB,   xlf_pkg::SIZE_WORD,  64'hFFFF, 64'h1, 1'b0);
    send_req(xlf_pkg::CMD_SUB,   xlf_pkg::SIZE_DWORD, 64'h7FFF_FFFF, 64'hFFFF_FFFF, 1'b0);
    send_req(xlf_pkg::CMD_LOGIC, xlf_pkg::SIZE_QWORD, ONES, ONES, 1'b1);
    send_req(xlf_pkg::CMD_INC,   xlf_pkg::SIZE_BYTE,  64'h80, 64'h1, 1'b0);
    send_req(xlf_pkg::CMD_INC,   xlf_pkg::SIZE_WORD,  64'h10, 64'h0, 1'b0);
    send_req(xlf_pkg::CMD_DEC,   xlf_pkg::SIZE_BYTE,  64'h7F, ONES, 1'b0);
    send_req(xlf_pkg::CMD_DEC,   xlf_pkg::SIZE_QWORD, ONES, 64'h0, 1'b0);
    send_req(xlf_pkg::CMD_SHL,   xlf_pkg::SIZE_DWORD, 64'h0, 64'h8000_0000, 1'b0);
    send_req(xlf_pkg::CMD_SAR,   xlf_pkg::SIZE_BYTE,  64'hC0, 64'h81, 1'b0);
    send_req(xlf_pkg::CMD_MUL,   xlf_pkg::SIZE_QWORD, 64'h0, 64'h0, 1'b0);
    send_req(xlf_pkg::CMD_MUL,   xlf_pkg::SIZE_BYTE,  64'h5A, 64'h100, 1'b0);
    send_req(xlf_pkg::CMD_BMI,   xlf_pkg::SIZE_WORD,  64'h0, 64'h0, 1'b0);
    send_req(xlf_pkg::CMD_BMI,   xlf_pkg::SIZE_QWORD, 64'h8000_0000_0000_0000, ONES, 1'b0);
    send_req(xlf_pkg::CMD_ADC,   xlf_pkg::SIZE_BYTE,  64'h55, 64'h55, 1'b1);
    send_req(xlf_pkg::CMD_ADC,   xlf_pkg::SIZE_QWORD, ONES, ONES, 1'b0);
    send_req(xlf_pkg::CMD_ADC,   xlf_pkg::SIZE_DWORD, 64'h1, 64'h2, 1'b0);
    for (int c = xlf_pkg::CMD_ADC + 1; c <= 15; c++)
      send_req(4'(c), 2'(c), ONES, ONES, 1'b1);

    for (int i = 0; i < 1600; i++) begin
      if (i == 400) long_hold = 1'b1;
      if (i == 1200) idle_on = 1'b0;
      if ($urandom_range(0, 19) == 0) cmd = 4'($urandom_range(xlf_pkg::CMD_ADC + 1, 15));
      else cmd = 4'($urandom_range(xlf_pkg::CMD_ADD, xlf_pkg::CMD_ADC));
      size = 2'($urandom_range(xlf_pkg::SIZE_BYTE, xlf_pkg::SIZE_QWORD));
      src  = pick_value(size);
      res  = pick_value(size);
      // mostly consistent operand pairs for add/sub/inc/dec/shl
      if ($urandom_range(0, 2) != 0) begin
        case (cmd)
          xlf_pkg::CMD_ADD: res = src + pick_value(size);
          xlf_pkg::CMD_SUB: res = pick_value(size) - src;
          xlf_pkg::CMD_INC: res = pick_value(size) + 64'd1;
          xlf_pkg::CMD_DEC: res = pick_value(size) - 64'd1;
          xlf_pkg::CMD_SHL: res = src << 1;
          default: ;
        endcase
      end
      send_req(cmd, size, res, src, 1'($urandom));
    end
    in_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/xlf_pkg.sv
rtl/xlf_mask.sv
rtl/xlf_arith.sv
rtl/xlf_flags.sv
rtl/x86_lazy_flags_evaluator_top.sv
sim/x86_lazy_flags_evaluator_checker.sv
sim/tb.sv
